// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the DHCP reply parser; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define DRP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset
`define DRP_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define DRP_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: hdl/drp_pkg.sv
// ----------------------------------------------------------------------------
// drp_pkg
// Types, constants and helpers shared by the DHCP reply parser.
// ----------------------------------------------------------------------------
package drp_pkg;

	// Option area size default
	localparam int OPTIONS_MAX_DEF = 308;

	// Fixed header layout
	localparam int          HEADER_BYTES  = 240;
	localparam int          POS_OPCODE    = 0;
	localparam int          POS_XID_FIRST = 4;
	localparam int          POS_XID_LAST  = 7;
	localparam int          POS_YI_FIRST  = 16;
	localparam int          POS_YI_LAST   = 19;
	localparam int          POS_SI_FIRST  = 20;
	localparam int          POS_SI_LAST   = 23;
	localparam int          POS_CK_FIRST  = 236;
	localparam int          POS_CK_LAST   = 239;
	localparam logic [7:0]  OPCODE_REPLY  = 8'd2;
	localparam logic [31:0] MAGIC_COOKIE  = 32'h6382_5363;

	// Option codes
	localparam logic [7:0] OPT_PAD    = 8'd0;
	localparam logic [7:0] OPT_MASK   = 8'd1;
	localparam logic [7:0] OPT_ROUTER = 8'd3;
	localparam logic [7:0] OPT_DNS    = 8'd6;
	localparam logic [7:0] OPT_LEASE  = 8'd51;
	localparam logic [7:0] OPT_TYPE   = 8'd53;
	localparam logic [7:0] OPT_SERVER = 8'd54;
	localparam logic [7:0] OPT_END    = 8'd255;

	// Outcome codes
	localparam logic [2:0] OUT_ACCEPTED     = 3'd0;
	localparam logic [2:0] OUT_TOO_SHORT    = 3'd1;
	localparam logic [2:0] OUT_NOT_REPLY    = 3'd2;
	localparam logic [2:0] OUT_XID_MISMATCH = 3'd3;
	localparam logic [2:0] OUT_BAD_COOKIE   = 3'd4;

	// Header check flags
	localparam int CHK_OPCODE = 0;
	localparam int CHK_XID    = 1;
	localparam int CHK_COOKIE = 2;

	// Option walk phase
	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_BODY,
		PH_DONE
	} phase_t;

	// Input transfer
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	// Result transfer
	typedef struct packed {
		logic [2:0]  outcome;
		logic [7:0]  message_kind;
		logic [31:0] assigned_address;
		logic [31:0] server_address;
		logic [31:0] mask_value;
		logic [31:0] router_address;
		logic [31:0] dns_primary;
		logic [31:0] dns_secondary;
		logic [31:0] lease_seconds;
	} out_t;

	// Byte of a big-endian word, index 0 being the most significant byte
	function automatic logic [7:0] word_byte(input logic [31:0] word, input logic [1:0] idx);
		logic [7:0] sel;
		case (idx)
			2'd0:    sel = word[31:24];
			2'd1:    sel = word[23:16];
			2'd2:    sel = word[15:8];
			default: sel = word[7:0];
		endcase
		return sel;
	endfunction

endpackage

// File: hdl/dhcp_reply_parser_top.sv
// ----------------------------------------------------------------------------
// dhcp_reply_parser_top
// Streaming DHCP reply checker and option extractor.
//
// Feed the UDP payload of a DHCP reply one byte per transfer on in_data, with
// last_byte set on the final byte; exactly one result comes out for that byte
// and none for the others. The block takes one byte per cycle unless stalled:
// each byte passes an input register, then the header and option logic
// updates the parse state, and the last byte loads the result register.
// The only stall is a last byte meeting a result that has not yet been taken.
// The result gives an outcome (accepted, too short, not a reply, transaction
// mismatch, bad cookie, in that priority); for a rejected packet all other
// fields are zero. Options are taken from up to OPTIONS_MAX bytes after the
// 240-byte header, an option counting only once its body is complete. Write
// cfg_wdata with cfg_we only between packets.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhcp_reply_parser_top import drp_pkg::*; #(
	parameter int OPTIONS_MAX = OPTIONS_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int LIMIT = HEADER_BYTES + OPTIONS_MAX;
	localparam int POS_W = $clog2(LIMIT + 1);

	// Input register
	logic        in_valid_s1;
	in_t         in_s1;

	// Configuration
	logic [31:0] xid_q;

	// Parse state
	logic [POS_W-1:0] pos_q, pos_d;
	phase_t           phase_q, phase_d;
	logic [7:0]       code_q, code_d;
	logic [7:0]       len_q, len_d;
	logic [7:0]       count_q, count_d;
	logic [7:0]       body_q [8];
	logic [7:0]       body_d [8];
	logic [2:0]       checks_q, checks_d;
	logic [31:0]      yi_q, yi_d;
	logic [31:0]      si_q, si_d;
	logic [7:0]       type_q, type_d;
	logic [31:0]      server_q, server_d;
	logic [31:0]      mask_q, mask_d;
	logic [31:0]      router_q, router_d;
	logic [31:0]      dns1_q, dns1_d;
	logic [31:0]      dns2_q, dns2_d;
	logic [31:0]      lease_q, lease_d;

	// Result register
	logic        out_valid_q;
	out_t        out_q;
	out_t        result;

	logic        proc_en;
	logic        in_area;
	logic        hdr_byte;
	logic        opt_byte;
	logic [7:0]  b;
	logic [7:0]  count_inc;
	logic        body_done;
	logic [31:0] word0;
	logic [31:0] word1;

	assign b        = in_s1.data_byte;
	assign in_area  = pos_q < POS_W'(LIMIT);
	assign hdr_byte = in_area && (pos_q < POS_W'(HEADER_BYTES));
	assign opt_byte = in_area && !hdr_byte;

	// Advance the stage unless a last byte would overwrite an untaken result
	assign proc_en  = in_valid_s1 && (!in_s1.last_byte || !out_valid_q || out_ready);
	assign in_ready = !in_valid_s1 || proc_en;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Expected transaction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xid_q <= 32'd0;
		end else if (cfg_we) begin
			xid_q <= cfg_wdata;
		end
	end

	// Option walk: next phase
	assign count_inc = count_q + 8'd1;
	assign body_done = count_inc >= len_q;

	always_comb begin
		phase_d = phase_q;
		if (opt_byte) begin
			unique case (phase_q)
				PH_CODE: begin
					if (b == OPT_END) begin
						phase_d = PH_DONE;
					end else if (b != OPT_PAD) begin
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					phase_d = (b == 8'd0) ? PH_CODE : PH_BODY;
				end
				PH_BODY: begin
					if (body_done) begin
						phase_d = PH_CODE;
					end
				end
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	// Body words as they stand with the current byte placed
	assign word0 = {body_d[0], body_d[1], body_d[2], body_d[3]};
	assign word1 = {body_d[4], body_d[5], body_d[6], body_d[7]};

	// Option walk and header: datapath
	always_comb begin
		code_d   = code_q;
		len_d    = len_q;
		count_d  = count_q;
		body_d   = body_q;
		type_d   = type_q;
		server_d = server_q;
		mask_d   = mask_q;
		router_d = router_q;
		dns1_d   = dns1_q;
		dns2_d   = dns2_q;
		lease_d  = lease_q;
		checks_d = checks_q;
		yi_d     = yi_q;
		si_d     = si_q;
		pos_d    = in_area ? pos_q + POS_W'(1) : pos_q;

		// Header checks and address capture
		if (hdr_byte) begin
			if (pos_q == POS_W'(POS_OPCODE) && b != OPCODE_REPLY) begin
				checks_d[CHK_OPCODE] = 1'b1;
			end
			if (pos_q >= POS_W'(POS_XID_FIRST) && pos_q <= POS_W'(POS_XID_LAST)
				&& b != word_byte(xid_q, pos_q[1:0])) begin
				checks_d[CHK_XID] = 1'b1;
			end
			if (pos_q >= POS_W'(POS_YI_FIRST) && pos_q <= POS_W'(POS_YI_LAST)) begin
				yi_d = {yi_q[23:0], b};
			end
			if (pos_q >= POS_W'(POS_SI_FIRST) && pos_q <= POS_W'(POS_SI_LAST)) begin
				si_d = {si_q[23:0], b};
			end
			if (pos_q >= POS_W'(POS_CK_FIRST) && pos_q <= POS_W'(POS_CK_LAST)
				&& b != word_byte(MAGIC_COOKIE, pos_q[1:0])) begin
				checks_d[CHK_COOKIE] = 1'b1;
			end
		end

		// Option bytes
		if (opt_byte) begin
			unique case (phase_q)
				PH_CODE: begin
					if (b != OPT_PAD && b != OPT_END) begin
						code_d = b;
					end
				end
				PH_LEN: begin
					len_d   = b;
					count_d = 8'd0;
					for (int i = 0; i < 8; i++) begin
						body_d[i] = 8'd0;
					end
				end
				PH_BODY: begin
					if (count_q < 8'd8) begin
						body_d[count_q[2:0]] = b;
					end
					count_d = count_inc;
					// Apply the option once its body is complete
					if (body_done) begin
						case (code_q)
							OPT_TYPE: begin
								type_d = body_d[0];
							end
							OPT_MASK: begin
								if (len_q >= 8'd4) mask_d = word0;
							end
							OPT_ROUTER: begin
								if (len_q >= 8'd4) router_d = word0;
							end
							OPT_DNS: begin
								if (len_q >= 8'd4) dns1_d = word0;
								if (len_q >= 8'd8) dns2_d = word1;
							end
							OPT_LEASE: begin
								if (len_q >= 8'd4) lease_d = word0;
							end
							OPT_SERVER: begin
								if (len_q >= 8'd4) server_d = word0;
							end
							default: begin
							end
						endcase
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Parse state; clear after each packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_CODE;
			code_q   <= 8'd0;
			len_q    <= 8'd0;
			count_q  <= 8'd0;
			checks_q <= 3'd0;
			yi_q     <= 32'd0;
			si_q     <= 32'd0;
			type_q   <= 8'd0;
			server_q <= 32'd0;
			mask_q   <= 32'd0;
			router_q <= 32'd0;
			dns1_q   <= 32'd0;
			dns2_q   <= 32'd0;
			lease_q  <= 32'd0;
			for (int i = 0; i < 8; i++) begin
				body_q[i] <= 8'd0;
			end
		end else if (proc_en) begin
			if (in_s1.last_byte) begin
				pos_q    <= '0;
				phase_q  <= PH_CODE;
				code_q   <= 8'd0;
				len_q    <= 8'd0;
				count_q  <= 8'd0;
				checks_q <= 3'd0;
				yi_q     <= 32'd0;
				si_q     <= 32'd0;
				type_q   <= 8'd0;
				server_q <= 32'd0;
				mask_q   <= 32'd0;
				router_q <= 32'd0;
				dns1_q   <= 32'd0;
				dns2_q   <= 32'd0;
				lease_q  <= 32'd0;
				for (int i = 0; i < 8; i++) begin
					body_q[i] <= 8'd0;
				end
			end else begin
				pos_q    <= pos_d;
				phase_q  <= phase_d;
				code_q   <= code_d;
				len_q    <= len_d;
				count_q  <= count_d;
				checks_q <= checks_d;
				yi_q     <= yi_d;
				si_q     <= si_d;
				type_q   <= type_d;
				server_q <= server_d;
				mask_q   <= mask_d;
				router_q <= router_d;
				dns1_q   <= dns1_d;
				dns2_q   <= dns2_d;
				lease_q  <= lease_d;
				body_q   <= body_d;
			end
		end
	end

	// Build the result from the state after the last byte
	always_comb begin
		result = '0;
		if (pos_d < POS_W'(HEADER_BYTES)) begin
			result.outcome = OUT_TOO_SHORT;
		end else if (checks_d[CHK_OPCODE]) begin
			result.outcome = OUT_NOT_REPLY;
		end else if (checks_d[CHK_XID]) begin
			result.outcome = OUT_XID_MISMATCH;
		end else if (checks_d[CHK_COOKIE]) begin
			result.outcome = OUT_BAD_COOKIE;
		end else begin
			result.outcome          = OUT_ACCEPTED;
			result.message_kind     = type_d;
			result.assigned_address = yi_d;
			result.server_address   = (server_d != 32'd0) ? server_d : si_d;
			result.mask_value       = mask_d;
			result.router_address   = router_d;
			result.dns_primary      = dns1_d;
			result.dns_secondary    = dns2_d;
			result.lease_seconds    = lease_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_en && in_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en && in_s1.last_byte) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	`DRP_ASSERT(a_reject_clear, clk, arst_n, out_valid_q && (out_q.outcome != OUT_ACCEPTED) |-> (out_q.message_kind == 8'd0) && (out_q.server_address == 32'd0) && (out_q.assigned_address == 32'd0) && (out_q.lease_seconds == 32'd0), "rejected packet carries field data")
	`DRP_ASSERT(a_body_count, clk, arst_n, (phase_q == PH_BODY) |-> (count_q < len_q), "option body count overran its length")
	`DRP_NEVER(a_pos_range, clk, arst_n, pos_q > POS_W'(LIMIT), "byte position beyond option area limit")
	`DRP_ASSERT(a_last_hold, clk, arst_n, in_valid_s1 && in_s1.last_byte && out_valid_q && !out_ready |=> in_valid_s1 && $stable(pos_q), "last byte processed while result still pending")

endmodule

// File: sim/dhcp_reply_parser_top_test.sv
// ============================================================================
// DHCP reply parser testbench
// Streams DHCP reply payloads into dhcp_reply_parser_top one byte per transfer.
// A table of hand-built packets runs first, then randomised replies under
// three idling patterns and several transaction id settings. Each result is
// checked against a parser model kept inside the bench or, for the rejection rows of the table, their fixed outcome.
// ============================================================================
module dhcp_reply_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import drp_pkg::*;

	localparam int AREA_END         = HEADER_BYTES + OPTIONS_MAX_DEF;
	localparam int RESET_CYCLES     = 12;
	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int SEGMENTS         = 6;
	localparam int PKTS_PER_SEGMENT = 10;
	localparam int STALL_LEN        = 800;
	localparam int STALL_AT_FIRST   = 25;
	localparam int STALL_AT_SECOND  = 55;
	localparam int SETTLE_CYCLES    = 4;
	localparam int REPORT_MAX       = 10;

	// Hand-built packet kinds
	typedef enum int {
		SC_TINY, SC_BARE, SC_XID_BAD, SC_CUT_239, SC_NOT_REPLY, SC_ALL_BAD,
		SC_XID_COOKIE, SC_COOKIE, SC_SHORT_BAD, SC_FULL, SC_PAD_END, SC_REPEAT,
		SC_SHORT_OPT, SC_LONG_OPT, SC_TRUNC_PKT, SC_TRUNC_AREA, SC_SRV_ZERO,
		SC_SI_ZERO, SC_ALL_FF, SC_ALL_00, SC_ZERO_LEN
	} scenario_e;

	typedef struct {
		scenario_e  scen;
		bit         typed;
		logic [2:0] outcome;
	} plan_row_t;

	// Rejections carry their outcome here; the rest go through the parser model
	plan_row_t plan [21] = '{
		'{SC_TINY,       1'b1, OUT_TOO_SHORT},
		'{SC_BARE,       1'b0, OUT_ACCEPTED},
		'{SC_XID_BAD,    1'b1, OUT_XID_MISMATCH},
		'{SC_CUT_239,    1'b1, OUT_TOO_SHORT},
		'{SC_NOT_REPLY,  1'b1, OUT_NOT_REPLY},
		'{SC_ALL_BAD,    1'b1, OUT_NOT_REPLY},
		'{SC_XID_COOKIE, 1'b1, OUT_XID_MISMATCH},
		'{SC_COOKIE,     1'b1, OUT_BAD_COOKIE},
		'{SC_SHORT_BAD,  1'b1, OUT_TOO_SHORT},
		'{SC_FULL,       1'b0, OUT_ACCEPTED},
		'{SC_PAD_END,    1'b0, OUT_ACCEPTED},
		'{SC_REPEAT,     1'b0, OUT_ACCEPTED},
		'{SC_SHORT_OPT,  1'b0, OUT_ACCEPTED},
		'{SC_LONG_OPT,   1'b0, OUT_ACCEPTED},
		'{SC_TRUNC_PKT,  1'b0, OUT_ACCEPTED},
		'{SC_TRUNC_AREA, 1'b0, OUT_ACCEPTED},
		'{SC_SRV_ZERO,   1'b0, OUT_ACCEPTED},
		'{SC_SI_ZERO,    1'b0, OUT_ACCEPTED},
		'{SC_ALL_FF,     1'b0, OUT_ACCEPTED},
		'{SC_ALL_00,     1'b0, OUT_ACCEPTED},
		'{SC_ZERO_LEN,   1'b0, OUT_ACCEPTED}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_t         in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// Parser model state
	logic [31:0] xid_reg;
	int          p_pos;
	phase_t      p_phase;
	logic [7:0]  p_code;
	logic [7:0]  p_len;
	int          p_cnt;
	logic [63:0] p_cap;
	logic [2:0]  p_chk;
	logic [31:0] p_yi, p_si;
	logic [7:0]  p_type;
	logic [31:0] p_srv, p_mask, p_rtr, p_dns1, p_dns2, p_lease;

	// Bench bookkeeping
	logic [7:0]  frame [$];
	out_t        pending_replies [$];
	out_t        oldest_reply;
	int          send_idle = 37;
	int          recv_idle = 47;
	int          fail_count;
	int          results_seen;
	int          accepted_seen;
	int          bytes_sent;
	int          packets_sent;
	int          cycle_count;
	int          stall_left;
	int          stall_started = -1;

	dhcp_reply_parser_top #(
		.OPTIONS_MAX(OPTIONS_MAX_DEF)
	) dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.cfg_we,
		.cfg_wdata
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------
	function automatic void clear_parse();
		p_pos   = 0;
		p_phase = PH_CODE;
		p_code  = '0;
		p_len   = '0;
		p_cnt   = 0;
		p_cap   = '0;
		p_chk   = '0;
		p_yi    = '0;
		p_si    = '0;
		p_type  = '0;
		p_srv   = '0;
		p_mask  = '0;
		p_rtr   = '0;
		p_dns1  = '0;
		p_dns2  = '0;
		p_lease = '0;
	endfunction

	// Word starting at body byte 'first' among the bytes kept
	function automatic logic [31:0] body_word(input int first);
		int kept = (p_len > 8) ? 8 : int'(p_len);
		return 32'(p_cap >> (8 * (kept - first - 4)));
	endfunction

	// Commit a complete option
	function automatic void apply_option();
		int kept = (p_len > 8) ? 8 : int'(p_len);
		case (p_code)
			OPT_TYPE:   if (p_len >= 1) p_type = 8'(p_cap >> (8 * (kept - 1)));
			OPT_MASK:   if (p_len >= 4) p_mask = body_word(0);
			OPT_ROUTER: if (p_len >= 4) p_rtr = body_word(0);
			OPT_DNS: begin
				if (p_len >= 4) p_dns1 = body_word(0);
				if (p_len >= 8) p_dns2 = body_word(4);
			end
			OPT_LEASE:  if (p_len >= 4) p_lease = body_word(0);
			OPT_SERVER: if (p_len >= 4) p_srv = body_word(0);
			default: ;
		endcase
	endfunction

	function automatic void header_byte(input logic [7:0] b);
		if (p_pos == POS_OPCODE && b != OPCODE_REPLY)
			p_chk[CHK_OPCODE] = 1'b1;
		if (p_pos >= POS_XID_FIRST && p_pos <= POS_XID_LAST
				&& b != xid_reg[8 * (POS_XID_LAST - p_pos) +: 8])
			p_chk[CHK_XID] = 1'b1;
		if (p_pos >= POS_YI_FIRST && p_pos <= POS_YI_LAST)
			p_yi = {p_yi[23:0], b};
		if (p_pos >= POS_SI_FIRST && p_pos <= POS_SI_LAST)
			p_si = {p_si[23:0], b};
		if (p_pos >= POS_CK_FIRST && p_pos <= POS_CK_LAST
				&& b != MAGIC_COOKIE[8 * (POS_CK_LAST - p_pos) +: 8])
			p_chk[CHK_COOKIE] = 1'b1;
	endfunction

	function automatic void option_byte(input logic [7:0] b);
		case (p_phase)
			PH_CODE: begin
				if (b == OPT_END) begin
					p_phase = PH_DONE;
				end else if (b != OPT_PAD) begin
					p_code  = b;
					p_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				p_len = b;
				p_cnt = 0;
				p_cap = '0;
				if (b == 8'd0) begin
					apply_option();
					p_phase = PH_CODE;
				end else begin
					p_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				if (p_cnt < 8)
					p_cap = {p_cap[55:0], b};
				p_cnt++;
				if (p_cnt >= p_len) begin
					apply_option();
					p_phase = PH_CODE;
				end
			end
			default: ;
		endcase
	endfunction

	// Advance the model by one byte; the return value counts on the last byte only
	function automatic out_t parse_reply_byte(input logic [7:0] b, input bit last);
		out_t res = '0;
		if (p_pos < AREA_END) begin
			if (p_pos < HEADER_BYTES)
				header_byte(b);
			else
				option_byte(b);
			p_pos++;
		end
		if (last) begin
			if (p_pos < HEADER_BYTES)
				res.outcome = OUT_TOO_SHORT;
			else if (p_chk[CHK_OPCODE])
				res.outcome = OUT_NOT_REPLY;
			else if (p_chk[CHK_XID])
				res.outcome = OUT_XID_MISMATCH;
			else if (p_chk[CHK_COOKIE])
				res.outcome = OUT_BAD_COOKIE;
			else begin
				res.outcome          = OUT_ACCEPTED;
				res.message_kind     = p_type;
				res.assigned_address = p_yi;
				res.server_address   = (p_srv != '0) ? p_srv : p_si;
				res.mask_value       = p_mask;
				res.router_address   = p_rtr;
				res.dns_primary      = p_dns1;
				res.dns_secondary    = p_dns2;
				res.lease_seconds    = p_lease;
			end
			clear_parse();
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Packet building
	// ------------------------------------------------------------------
	task automatic build_header(input logic [7:0] op, input logic [31:0] xid,
			input logic [31:0] yi, input logic [31:0] si, input logic [31:0] ck);
		frame.delete();
		for (int i = 0; i < HEADER_BYTES; i++)
			frame.push_back(8'($urandom));
		frame[POS_OPCODE] = op;
		for (int k = 0; k < 4; k++) begin
			frame[POS_XID_FIRST + k] = xid[31 - 8 * k -: 8];
			frame[POS_YI_FIRST + k]  = yi[31 - 8 * k -: 8];
			frame[POS_SI_FIRST + k]  = si[31 - 8 * k -: 8];
			frame[POS_CK_FIRST + k]  = ck[31 - 8 * k -: 8];
		end
	endtask

	// Append code, length and body; a negative fill means random body bytes
	task automatic add_option(input logic [7:0] code, input int len, input int fill);
		frame.push_back(code);
		frame.push_back(8'(len));
		for (int i = 0; i < len; i++)
			frame.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
	endtask

	task automatic add_six(input int fill, input int dns_len);
		add_option(OPT_TYPE, 1, fill);
		add_option(OPT_MASK, 4, fill);
		add_option(OPT_ROUTER, 4, fill);
		add_option(OPT_DNS, dns_len, fill);
		add_option(OPT_LEASE, 4, fill);
		add_option(OPT_SERVER, 4, fill);
	endtask

	task automatic build_directed(input scenario_e s);
		logic [7:0]  op  = OPCODE_REPLY;
		logic [31:0] xid = xid_reg;
		logic [31:0] yi  = $urandom;
		logic [31:0] si  = $urandom;
		logic [31:0] ck  = MAGIC_COOKIE;
		// Header fields first
		case (s)
			SC_NOT_REPLY: op = 8'd1;
			SC_SHORT_BAD: op = 8'd0;
			SC_ALL_BAD: begin
				op  = 8'hFF;
				xid = ~xid_reg;
				ck  = ~MAGIC_COOKIE;
			end
			SC_XID_BAD: xid = xid_reg ^ 32'h0000_0100;
			SC_XID_COOKIE: begin
				xid = xid_reg ^ 32'h8000_0000;
				ck  = MAGIC_COOKIE ^ 32'h0000_0001;
			end
			SC_COOKIE:  ck = MAGIC_COOKIE ^ 32'h0100_0000;
			SC_SI_ZERO: si = '0;
			SC_ALL_FF: begin
				yi = '1;
				si = '1;
			end
			SC_ALL_00:  yi = '0;
			default: ;
		endcase
		build_header(op, xid, yi, si, ck);
		// Then the option area and any cut
		case (s)
			SC_TINY: begin
				frame.delete();
				frame.push_back(8'hFF);
			end
			SC_CUT_239:   frame = frame[0:HEADER_BYTES - 2];
			SC_SHORT_BAD: frame = frame[0:99];
			SC_FULL: begin
				add_six(-1, 8);
				frame.push_back(OPT_END);
			end
			SC_PAD_END: begin
				frame.push_back(OPT_PAD);
				frame.push_back(OPT_PAD);
				add_option(OPT_MASK, 4, -1);
				frame.push_back(OPT_END);
				// nothing after end counts
				add_option(OPT_TYPE, 1, -1);
				add_option(OPT_ROUTER, 4, -1);
				frame.push_back(OPT_PAD);
			end
			SC_REPEAT: begin
				add_six(-1, 8);
				add_six(-1, 4);
			end
			SC_SHORT_OPT: begin
				add_option(OPT_TYPE, 0, -1);
				add_option(OPT_MASK, 3, -1);
				add_option(OPT_DNS, 7, -1);
				add_option(OPT_SERVER, 2, -1);
				add_option(OPT_ROUTER, 1, -1);
				add_option(OPT_LEASE, 3, -1);
			end
			SC_LONG_OPT: begin
				add_option(OPT_LEASE, 12, -1);
				add_option(OPT_DNS, 20, -1);
				add_option(OPT_TYPE, 3, -1);
				add_option(OPT_SERVER, 9, -1);
				add_option(OPT_MASK, 5, -1);
				add_option(OPT_ROUTER, 8, -1);
			end
			SC_TRUNC_PKT: begin
				add_option(OPT_MASK, 4, -1);
				add_option(OPT_ROUTER, 4, -1);
				frame = frame[0:$ - 2];
			end
			SC_TRUNC_AREA: begin
				add_option(OPT_MASK, 4, -1);
				while (frame.size() < AREA_END - 8)
					frame.push_back(OPT_PAD);
				// straddles the end of the option area, the rest lies beyond it
				add_option(OPT_LEASE, 10, -1);
				add_option(OPT_SERVER, 4, -1);
				add_option(OPT_TYPE, 1, -1);
			end
			SC_SRV_ZERO: begin
				add_option(OPT_SERVER, 4, 0);
				add_option(OPT_TYPE, 1, -1);
			end
			SC_SI_ZERO:   add_option(OPT_TYPE, 1, -1);
			SC_ALL_FF: begin
				add_six(8'hFF, 8);
				add_option(8'd254, 255, 8'hFF);
			end
			SC_ALL_00:    add_six(8'h00, 8);
			SC_ZERO_LEN: begin
				add_six(-1, 0);
				add_option(OPT_TYPE, 0, -1);
				frame.push_back(OPT_END);
			end
			default: ;
		endcase
	endtask

	// Fill the option area with mostly well-formed options up to target bytes
	task automatic add_random_options(input int target);
		int         pick;
		int         len;
		logic [7:0] code;
		while (frame.size() < HEADER_BYTES + target) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				frame.push_back(OPT_PAD);
			end else if (pick < 12) begin
				frame.push_back(OPT_END);
				while (frame.size() < HEADER_BYTES + target)
					frame.push_back(8'($urandom));
			end else begin
				case (pick % 8)
					0:       code = OPT_TYPE;
					1:       code = OPT_MASK;
					2:       code = OPT_ROUTER;
					3:       code = OPT_DNS;
					4:       code = OPT_LEASE;
					5:       code = OPT_SERVER;
					default: code = 8'($urandom_range(254, 1));
				endcase
				if ($urandom_range(4) == 0)
					len = $urandom_range(12);
				else if (code == OPT_TYPE)
					len = 1;
				else if (code == OPT_DNS)
					len = $urandom_range(1) ? 8 : 4;
				else
					len = 4;
				add_option(code, len, -1);
			end
		end
	endtask

	task automatic build_random();
		int          pick = $urandom_range(99);
		int          cut;
		logic [7:0]  op;
		logic [31:0] xid;
		logic [31:0] si;
		logic [31:0] ck;
		op  = ($urandom_range(19) == 0) ? 8'($urandom) : OPCODE_REPLY;
		xid = ($urandom_range(9) == 0) ? xid_reg ^ (32'h1 << $urandom_range(31)) : xid_reg;
		ck  = ($urandom_range(19) == 0) ? MAGIC_COOKIE ^ (32'h1 << $urandom_range(31))
			: MAGIC_COOKIE;
		si  = ($urandom_range(4) == 0) ? '0 : $urandom;
		build_header(op, xid, $urandom, si, ck);
		if (pick < 20) begin
			// short packet, mostly very short
			cut = ($urandom_range(3) == 0) ? $urandom_range(HEADER_BYTES - 1, 1)
				: $urandom_range(40, 1);
			frame = frame[0:cut - 1];
		end else begin
			if (pick < 26)
				add_random_options($urandom_range(OPTIONS_MAX_DEF + 40, OPTIONS_MAX_DEF - 20));
			else
				add_random_options($urandom_range(64));
			if ($urandom_range(6) == 0)
				frame = frame[0:$urandom_range(frame.size() - 1, HEADER_BYTES - 1)];
		end
	endtask

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------
	// Send the frame; called and returning just after a falling edge
	task automatic send_packet(input bit typed, input logic [2:0] typed_outcome);
		out_t predicted;
		out_t fixed_reply;
		bit   last;
		for (int i = 0; i < frame.size(); i++) begin
			last = (i == frame.size() - 1);
			while ($urandom_range(99) < send_idle) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid <= 1'b1;
			in_data  <= '{data_byte: frame[i], last_byte: last};
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			predicted = parse_reply_byte(frame[i], last);
			bytes_sent++;
			if (last) begin
				fixed_reply         = '0;
				fixed_reply.outcome = typed_outcome;
				pending_replies.push_back(typed ? fixed_reply : predicted);
			end
			@(negedge clk);
		end
		packets_sent++;
	endtask

	// Write the transaction id register once the block has gone quiet
	task automatic load_xid(input logic [31:0] value);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we  <= 1'b0;
		xid_reg  = value;
	endtask

	// Receiver: random idling, plus two long hold-offs to fill the block
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ((results_seen == STALL_AT_FIRST || results_seen == STALL_AT_SECOND)
				&& stall_started != results_seen) begin
			stall_started <= results_seen;
			stall_left    <= STALL_LEN;
			out_ready     <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic string show_reply(input out_t r);
		return $sformatf({"outcome %0d kind %02h yiaddr %08h server %08h mask %08h ",
			"router %08h dns %08h/%08h lease %08h"}, r.outcome, r.message_kind,
			r.assigned_address, r.server_address, r.mask_value, r.router_address,
			r.dns_primary, r.dns_secondary, r.lease_seconds);
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	// Compare each result transfer with the oldest reply due
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("cycle %0d: result with none due: %s", cycle_count,
						show_reply(out_data));
			end else begin
				oldest_reply = pending_replies.pop_front();
				if (oldest_reply.outcome == OUT_ACCEPTED)
					accepted_seen++;
				if (out_data !== oldest_reply) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("cycle %0d: reply mismatch", cycle_count);
						$display("  due: %s", show_reply(oldest_reply));
						$display("  got: %s", show_reply(out_data));
					end
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still due", cycle_count,
				pending_replies.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [31:0] seg_xid [SEGMENTS];
		seg_xid[0] = $urandom;
		seg_xid[1] = 32'h0000_0000;
		seg_xid[2] = 32'hFFFF_FFFF;
		seg_xid[3] = $urandom;
		seg_xid[4] = 32'h0000_0001;
		seg_xid[5] = $urandom;
		xid_reg = '0;
		clear_parse();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed table: the first rows rely on the register's reset value
		for (int i = 0; i < $size(plan); i++) begin
			if (i == 3)
				load_xid(32'hFFFF_FFFF);
			build_directed(plan[i].scen);
			send_packet(plan[i].typed, plan[i].outcome);
		end

		// Random replies: receiver-heavy idling, then sender-heavy, then none
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle = 37;
					recv_idle = 47;
				end
				1: begin
					send_idle = 47;
					recv_idle = 37;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			load_xid(seg_xid[seg]);
			for (int p = 0; p < PKTS_PER_SEGMENT; p++) begin
				build_random();
				send_packet(1'b0, OUT_ACCEPTED);
			end
		end
		in_valid <= 1'b0;

		// Drain, then allow for the pipeline
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);

		$display("Ran %0d bytes in %0d packets over %0d cycles; %0d results, %0d accepted.",
			bytes_sent, packets_sent, cycle_count, results_seen, accepted_seen);
		$display("Covered %0d transaction id settings, three idling patterns, %0d failures.",
			SEGMENTS + 1, fail_count);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
